// ----- sv/fupe_pkg.sv -----
// Shared types and helpers for the form-post URL encoder.
// Holds the item kind, the queue entry layout and the character/encoding functions.
// No dependencies.
package fupe_pkg;

	// What the front end decided one input byte expands into
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,  // URL-encode the byte itself
		KIND_LT   = 2'd1,  // "&lt;"
		KIND_GT   = 2'd2,  // "&gt;"
		KIND_QUOT = 2'd3   // "&quot;"
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} entry_t;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam int unsigned CIDX_W = 3;

	// Index of the final character of the text for a kind
	function automatic logic [CIDX_W-1:0] last_idx(input kind_t kind);
		logic [CIDX_W-1:0] r;
		unique case (kind)
			KIND_BYTE: r = 3'd0;
			KIND_LT:   r = 3'd3;
			KIND_GT:   r = 3'd3;
			KIND_QUOT: r = 3'd5;
			default:   r = 3'd0;
		endcase
		return r;
	endfunction

	// Character number idx of the text that a kind stands for
	function automatic logic [7:0] char_at(input kind_t kind, input logic [7:0] data,
			input logic [CIDX_W-1:0] idx);
		logic [7:0] r;
		r = data;
		unique case (kind)
			KIND_BYTE: r = data;
			KIND_LT, KIND_GT: begin
				case (idx)
					3'd0:    r = CH_AMP;
					3'd1:    r = (kind == KIND_LT) ? 8'h6C : 8'h67;  // 'l' / 'g'
					3'd2:    r = 8'h74;                              // 't'
					default: r = CH_SEMI;
				endcase
			end
			KIND_QUOT: begin
				case (idx)
					3'd0:    r = CH_AMP;
					3'd1:    r = 8'h71;  // 'q'
					3'd2:    r = 8'h75;  // 'u'
					3'd3:    r = 8'h6F;  // 'o'
					3'd4:    r = 8'h74;  // 't'
					default: r = CH_SEMI;
				endcase
			end
			default: r = data;
		endcase
		return r;
	endfunction

	// Letters, digits, '.', '-' and '_' pass unchanged
	function automatic logic is_plain(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h61 && b <= 8'h7A) || b == CH_DOT || b == CH_DASH ||
			b == CH_UNDER;
	endfunction

	// Uppercase hex digit
	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
	endfunction

	// Lead byte ranges of the double-byte encoding
	function automatic logic is_lead(input logic [7:0] b);
		return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hEF);
	endfunction

endpackage

// ----- sv/fupe_front.sv -----
// Front end: accepts input bytes, tracks double-byte state and classifies each byte.
// Depends on fupe_pkg.
module fupe_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_byte,
	input  logic            in_eos,
	input  logic            in_take,
	output fupe_pkg::entry_t entry
);
	import fupe_pkg::*;

	logic trail_q;
	logic trail_d;

	always_comb begin
		entry.data = in_byte;
		entry.kind = KIND_BYTE;
		trail_d    = 1'b0;
		if (trail_q) begin
			trail_d = 1'b0;
		end else if (is_lead(in_byte)) begin
			trail_d = 1'b1;
		end else if (in_byte == CH_LT) begin
			entry.kind = KIND_LT;
		end else if (in_byte == CH_GT) begin
			entry.kind = KIND_GT;
		end else if (in_byte == CH_QUOTE) begin
			entry.kind = KIND_QUOT;
		end
		// end of string drops any pending trail byte
		if (in_eos) begin
			trail_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trail_q <= 1'b0;
		end else if (in_valid && in_take) begin
			trail_q <= trail_d;
		end
	end

endmodule

// ----- sv/fupe_fifo.sv -----
// Short queue of classified entries between front and back end.
// Depends on fupe_pkg.
module fupe_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fupe_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output fupe_pkg::entry_t head
);
	import fupe_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_FULL);
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/fupe_back.sv -----
// Back end: expands one queued entry into its URL-encoded output bytes.
// Depends on fupe_pkg.
module fupe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             have_entry,
	input  fupe_pkg::entry_t head,
	output logic             pop,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             out_last,
	input  logic             out_ready
);
	import fupe_pkg::*;

	typedef enum logic [1:0] {
		ST_FIRST,  // plain char, '+' or '%'
		ST_HI,     // high hex digit
		ST_LO      // low hex digit
	} state_t;

	state_t            state_q;
	logic [CIDX_W-1:0] cidx_q;
	logic              valid_q;
	logic [7:0]        byte_q;
	logic              last_q;

	logic [7:0] ch;
	logic       fire;
	logic       char_done;
	logic       run_done;
	logic [7:0] emit;

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	assign fire = have_entry && (!valid_q || out_ready);
	assign ch   = char_at(head.kind, head.data, cidx_q);

	always_comb begin
		emit      = CH_PCT;
		char_done = 1'b0;
		unique case (state_q)
			ST_FIRST: begin
				if (is_plain(ch)) begin
					emit      = ch;
					char_done = 1'b1;
				end else if (ch == CH_SPACE) begin
					emit      = CH_PLUS;
					char_done = 1'b1;
				end
			end
			ST_HI: emit = hex_digit(ch[7:4]);
			ST_LO: begin
				emit      = hex_digit(ch[3:0]);
				char_done = 1'b1;
			end
			default: emit = CH_PCT;
		endcase
	end

	assign run_done = char_done && (cidx_q == last_idx(head.kind));
	assign pop      = fire && run_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FIRST;
			cidx_q  <= '0;
			valid_q <= 1'b0;
			byte_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			if (fire) begin
				valid_q <= 1'b1;
				byte_q  <= emit;
				last_q  <= run_done;
				unique case (state_q)
					ST_FIRST: state_q <= char_done ? ST_FIRST : ST_HI;
					ST_HI:    state_q <= ST_LO;
					ST_LO:    state_q <= ST_FIRST;
					default:  state_q <= ST_FIRST;
				endcase
				if (run_done) begin
					cidx_q <= '0;
				end else if (char_done) begin
					cidx_q <= cidx_q + 1'b1;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/form_post_url_encoder_core.sv -----
// Top level of the form-post URL encoder.
// Depends on fupe_pkg, fupe_front, fupe_fifo and fupe_back.
//
// Usage:
//   Input stream (s_*): one raw byte of a double-byte-encoded string per
//   request in s_tdata[7:0]; s_tlast marks the last byte of a string.
//   Output stream (m_*): one ASCII byte per request in m_tdata[7:0];
//   m_tlast marks the final output byte produced by one input byte.
//   Expansion: letters, digits, '.', '-', '_' give 1 byte, space gives '+',
//   any other byte gives "%XY" (3 bytes). Outside a double-byte character,
//   '<' and '>' give 8 bytes ("&lt;"/"&gt;" encoded) and '"' gives 10.
//   Throughput: the back end emits one output byte per cycle while an entry
//   is queued and m_tready does not stall it, so an input byte costs 1, 3,
//   8 or 10 output bytes; the output rate sets the sustained input rate.
//   An accepted byte passes the queue write, then the output register.
//   The front end accepts while the 4-entry queue has room, so it keeps
//   taking bytes while the back end works or the receiver stalls.
//   Stall: when m_tready is low the output register holds; the back end
//   stops, the queue fills and then s_tready drops.
//   Reset: arst_n clears the double-byte state, the queue and the output
//   valid; the queue starts empty, so s_tready is high once reset is released.
module form_post_url_encoder_core #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // end_of_string
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast    // last_of_run
);
	import fupe_pkg::*;

	entry_t front_entry;
	entry_t head;
	logic   q_full;
	logic   q_not_empty;
	logic   q_pop;
	logic   q_push;

	// accept whenever the queue has a free slot
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	// classify the byte and track the pending trail byte
	fupe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_eos   (s_tlast),
		.in_take  (s_tready),
		.entry    (front_entry)
	);

	// decouple acceptance from expansion
	fupe_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (front_entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	// expand entries, one output byte per cycle while the output is not stalled
	fupe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.have_entry (q_not_empty),
		.head       (head),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_byte   (m_tdata),
		.out_last   (m_tlast),
		.out_ready  (m_tready)
	);

endmodule

// ----- test/form_post_url_encoder_core_tb.sv -----
// Self-checking testbench for form_post_url_encoder_core.
// Drives double-byte-encoded text requests and checks every output byte against an in-bench model.
// Depends on fupe_pkg and the encoder RTL.
module form_post_url_encoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fupe_pkg::*;

	// One expected output byte and whether it closes the run of its input byte
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} enc_byte_t;

	localparam int ITEM_TARGET = 230;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;

	// Encoded bytes still owed by the block, oldest first
	enc_byte_t  expected_q[$];
	// Characters of the run being built for one input byte
	logic [7:0] run_chars[$];
	// Model copy of the double-byte state: next byte is a trail byte
	logic       dbcs_trail;

	// Idling controls shared by the request driver and the sink
	bit src_idle;
	bit sink_stalls;
	int sink_hold_req;

	int fail_count;
	int items_sent;
	int bytes_checked;
	int entity_runs;
	int dbcs_chars;

	form_post_url_encoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Encoding model
	// ------------------------------------------------------------------

	// Append the URL form of one byte: plain characters as they are, space as '+',
	// everything else as %XY with uppercase hex.
	function automatic void add_url_byte(input logic [7:0] b);
		string hex_text;
		hex_text = "0123456789ABCDEF";
		if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
				(b >= 8'h61 && b <= 8'h7A) || b == CH_DOT || b == CH_DASH ||
				b == CH_UNDER) begin
			run_chars.push_back(b);
		end else if (b == CH_SPACE) begin
			run_chars.push_back(CH_PLUS);
		end else begin
			run_chars.push_back(CH_PCT);
			run_chars.push_back(hex_text[b[7:4]]);
			run_chars.push_back(hex_text[b[3:0]]);
		end
	endfunction

	// Work out the full run for one accepted byte and queue it up.
	function automatic void predict_encoding(input logic [7:0] b, input logic eos);
		kind_t      kind;
		string      entity;
		int         i;
		enc_byte_t  e;
		run_chars.delete();
		kind = KIND_BYTE;
		if (dbcs_trail) begin
			// trail byte: never a lead, never an entity character
			dbcs_trail = 1'b0;
			dbcs_chars++;
		end else if ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hEF)) begin
			dbcs_trail = 1'b1;
		end else if (b == CH_LT) begin
			kind = KIND_LT;
		end else if (b == CH_GT) begin
			kind = KIND_GT;
		end else if (b == CH_QUOTE) begin
			kind = KIND_QUOT;
		end
		case (kind)
			KIND_LT:   entity = "&lt;";
			KIND_GT:   entity = "&gt;";
			KIND_QUOT: entity = "&quot;";
			default:   entity = "";
		endcase
		if (kind == KIND_BYTE) begin
			add_url_byte(b);
		end else begin
			entity_runs++;
			for (i = 0; i < entity.len(); i++)
				add_url_byte(entity[i]);
		end
		// a lead byte that ends the string leaves no trail pending
		if (eos)
			dbcs_trail = 1'b0;
		for (i = 0; i < run_chars.size(); i++) begin
			e.out_byte    = run_chars[i];
			e.last_of_run = (i == run_chars.size() - 1);
			expected_q.push_back(e);
		end
	endfunction

	// ------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------

	// Offer one byte, hold it until accepted, then predict its run.
	// A random idle burst may go first when source idling is on.
	task automatic send_request(input logic [7:0] b, input logic eos);
		int gap;
		if (src_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eos;
		do
			@(posedge clk);
		while (!s_tready);
		predict_encoding(b, eos);
		items_sent++;
	endtask

	// Drop the request line after the last byte of a phase
	task automatic release_source();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Hold until every expected byte has come out
	task automatic wait_drained();
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Sink: ready pattern, and output checking
	// ------------------------------------------------------------------

	initial begin : sink_ready
		int run_len;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (sink_hold_req > 0) begin
				// long hold-off: let the queue fill and back-pressure the input
				run_len = sink_hold_req;
				sink_hold_req = 0;
				repeat (run_len) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
				run_len = $urandom_range(1, 19);
				repeat (run_len) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end else begin
				run_len = sink_stalls ? $urandom_range(1, 19) : 1;
				repeat (run_len) begin
					@(negedge clk);
					m_tready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin : check_output
		enc_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected output byte 0x%02h (last %0b)", m_tdata, m_tlast);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				bytes_checked++;
				if (m_tdata !== want.out_byte) begin
					$error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, m_tdata);
					fail_count++;
				end
				if (m_tlast !== want.last_of_run) begin
					$error("last_of_run: expected %0b, got %0b", want.last_of_run, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, every encoding class and the double-byte corner cases
	task automatic test_directed();
		send_request(8'h00, 1'b0);      // zero byte is ordinary, does not end the string
		send_request(8'hFF, 1'b0);
		send_request(CH_SPACE, 1'b0);
		send_request(8'h41, 1'b0);      // 'A'
		send_request(8'h7A, 1'b0);      // 'z'
		send_request(8'h30, 1'b0);      // '0'
		send_request(8'h39, 1'b0);      // '9'
		send_request(CH_DOT, 1'b0);
		send_request(CH_DASH, 1'b0);
		send_request(CH_UNDER, 1'b0);
		send_request(8'h40, 1'b0);      // just below the letters
		send_request(8'h5B, 1'b0);      // just above the letters
		send_request(CH_LT, 1'b0);
		send_request(CH_GT, 1'b0);
		send_request(CH_QUOTE, 1'b1);
		// entity characters as trail bytes are escaped as plain bytes
		send_request(8'h81, 1'b0);
		send_request(CH_LT, 1'b0);
		send_request(8'hEF, 1'b0);
		send_request(CH_QUOTE, 1'b1);
		// lead byte closing the string: the next string starts clean
		send_request(8'h9F, 1'b1);
		send_request(CH_GT, 1'b0);
		send_request(8'hE0, 1'b0);
		send_request(CH_SPACE, 1'b1);   // space as trail still becomes '+'
		send_request(8'h80, 1'b0);      // neighbors of the lead ranges
		send_request(8'hA0, 1'b0);
		send_request(8'hF0, 1'b1);
		release_source();
	endtask

	// Pick one byte that is neither a lead nor special outside a character
	function automatic logic [7:0] pick_plain();
		string plain_set;
		plain_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz.-_";
		return plain_set[$urandom_range(0, plain_set.len() - 1)];
	endfunction

	// One well-formed string of len bytes with random content
	task automatic send_sjis_string(input int len);
		int         k;
		logic [7:0] b;
		k = 0;
		while (k < len) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					send_request(pick_plain(), k == len - 1);
					k++;
				end
				3: begin
					case ($urandom_range(0, 3))
						0:       b = CH_LT;
						1:       b = CH_GT;
						2:       b = CH_QUOTE;
						default: b = CH_SPACE;
					endcase
					send_request(b, k == len - 1);
					k++;
				end
				4, 5: begin
					// double-byte character; the lead may land on the last byte
					b = $urandom_range(0, 1) ? 8'h81 + 8'($urandom_range(0, 30))
						: 8'hE0 + 8'($urandom_range(0, 15));
					send_request(b, k == len - 1);
					k++;
					if (k < len) begin
						case ($urandom_range(0, 5))
							0:       b = CH_LT;
							1:       b = CH_QUOTE;
							2:       b = 8'h81 + 8'($urandom_range(0, 30));
							3:       b = 8'($urandom_range(0, 255));
							default: b = 8'($urandom_range(8'h40, 8'hFC));
						endcase
						send_request(b, k == len - 1);
						k++;
					end
				end
				default: begin
					send_request(8'($urandom_range(0, 255)), k == len - 1);
					k++;
				end
			endcase
		end
	endtask

	// Keep offering requests while the sink holds off for a long stretch
	task automatic test_sink_holdoff();
		int i;
		src_idle = 1'b0;
		sink_hold_req = 300;
		for (i = 0; i < 24; i++)
			send_request(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		release_source();
		src_idle = 1'b1;
	endtask

	// Mostly well-formed strings, some raw noise with scattered string ends
	task automatic test_random_strings(input int target);
		int i;
		int len;
		while (items_sent < target) begin
			if ($urandom_range(0, 7) == 0) begin
				len = $urandom_range(1, 10);
				for (i = 0; i < len; i++)
					send_request(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end else begin
				send_sjis_string($urandom_range(1, 12));
			end
			// pause the source until the block is empty, in each pass that ends in a window below the target
			if (items_sent >= target - 60 && items_sent < target - 45) begin
				release_source();
				wait_drained();
			end
		end
		release_source();
	endtask

	// Back-to-back requests with the sink always ready
	task automatic test_full_rate();
		src_idle = 1'b0;
		sink_stalls = 1'b0;
		repeat (3)
			send_sjis_string($urandom_range(8, 12));
		release_source();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		dbcs_trail = 1'b0;
		src_idle = 1'b1;
		sink_stalls = 1'b1;
		sink_hold_req = 0;
		fail_count = 0;
		items_sent = 0;
		bytes_checked = 0;
		entity_runs = 0;
		dbcs_chars = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_sink_holdoff();
		test_random_strings(ITEM_TARGET - 30);
		test_full_rate();

		wait_drained();
		// allow any stray trailing output to show up
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes, checked %0d encoded bytes (%0d entity runs, %0d double-byte chars).",
			items_sent, bytes_checked, entity_runs, dbcs_chars);
		$display("Included a long sink hold-off, a full drain pause and a no-idle stretch.");
		if (fail_count == 0) begin
			$display("PASS form_post_url_encoder_core");
		end else begin
			$display("FAIL form_post_url_encoder_core");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("FAIL form_post_url_encoder_core");
		$finish;
	end

endmodule
